// ----- hw/rtl/pvl_pkg.sv -----
// ============================================================================
// pvl_pkg: shared definitions for the positional value list
// Command codes, status codes, cell operations and fixed field widths.
// ============================================================================
package pvl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int MODE_W       = 4;
    localparam int POS_W        = 8;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 4'd0,
        MODE_INS_BACK  = 4'd1,
        MODE_INS_AT    = 4'd2,
        MODE_DEL_FRONT = 4'd3,
        MODE_DEL_BACK  = 4'd4,
        MODE_DEL_AT    = 4'd5,
        MODE_UPD_FRONT = 4'd6,
        MODE_UPD_BACK  = 4'd7,
        MODE_UPD_AT    = 4'd8,
        MODE_CLEAR     = 4'd9,
        MODE_READ_ALL  = 4'd10
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_RANGE  = 3'd2,
        ST_NOTMID = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // what every cell of the chain does on the next edge
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,   // keep own value
        CELL_INS  = 3'd1,   // above idx take left neighbor, at idx load value
        CELL_DEL  = 3'd2,   // at or above idx take right neighbor
        CELL_UPD  = 3'd3,   // at idx load value
        CELL_ROT  = 3'd4    // below idx take right neighbor, at idx take front
    } cell_op_t;

endpackage

// ----- hw/rtl/pvl_cell.sv -----
// ============================================================================
// pvl_cell: one storage cell of the list chain
// Holds one word and, per the broadcast operation, keeps it, loads the
// command value or takes a neighbor's word.
// ============================================================================
module pvl_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                               clk,
    input  pvl_pkg::cell_op_t                  op,
    input  logic [IDX_W-1:0]                   idx,
    input  logic signed [pvl_pkg::DATA_W-1:0]  value,
    input  logic signed [pvl_pkg::DATA_W-1:0]  left_val,
    input  logic signed [pvl_pkg::DATA_W-1:0]  right_val,
    input  logic signed [pvl_pkg::DATA_W-1:0]  front_val,
    output logic signed [pvl_pkg::DATA_W-1:0]  q
);
    import pvl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = CELL_IDX[IDX_W-1:0];

    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (op)
            CELL_INS:
            begin
                if (MY_IDX > idx)
                    q_next = left_val;
                else if (MY_IDX == idx)
                    q_next = value;
            end
            CELL_DEL:
            begin
                if (MY_IDX >= idx)
                    q_next = right_val;
            end
            CELL_UPD:
            begin
                if (MY_IDX == idx)
                    q_next = value;
            end
            CELL_ROT:
            begin
                if (MY_IDX < idx)
                    q_next = right_val;
                else if (MY_IDX == idx)
                    q_next = front_val;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- hw/rtl/positional_value_list_top.sv -----
// ============================================================================
// positional_value_list_top: bounded ordered list of signed 32-bit words
// Insert, delete, update, clear and read-out on a chain of storage cells.
// ============================================================================
// A command word is taken at a rising edge with start high and busy low.
// Every command except a read-out of a non-empty list gives a single
// result, which shows on the next cycle with done and last high, and busy
// stays low, so commands may be issued back to back. Insert and delete
// move all later words at once, since every cell of the chain takes its
// neighbor's word in parallel. A read-out of N words raises busy after
// acceptance and gives one result per cycle, front to back, with last on
// the final one; the chain rotates one place per cycle and is back in
// order when the burst ends. A new command is taken the cycle the last
// result shows. Results are strobed on done for exactly one cycle and the
// receiver cannot hold them off. Entries never written read as anything,
// but only entries below the count are ever read. No clearing pass is
// needed after reset.
module positional_value_list_top #(
    parameter int CAPACITY = pvl_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [pvl_pkg::MODE_W-1:0]           mode,
    input  logic signed [pvl_pkg::DATA_W-1:0]    value,
    input  logic [pvl_pkg::POS_W-1:0]            position,
    output logic                                 done,
    output logic [pvl_pkg::STATUS_W-1:0]         status,
    output logic signed [pvl_pkg::DATA_W-1:0]    element,
    output logic [pvl_pkg::COUNT_W-1:0]          count,
    output logic                                 last
);
    import pvl_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] rd_reg;      // read-out position
    logic             done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic signed [DATA_W-1:0] element_reg;
    logic             last_reg;

    logic accept;
    logic go_read;
    cell_op_t op_c;
    logic [IDX_W-1:0] idx_c;
    status_t st_c;

    logic [CNT_W-1:0] cnt_m1;
    logic [POS_W-1:0] pos_m1;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic is_full;
    logic is_empty;
    status_t mid_st;

    logic signed [DATA_W-1:0] vals [CAPACITY];

    assign accept   = start && (state_reg == S_IDLE);
    assign cnt_m1   = cnt_reg - 1'b1;
    assign pos_m1   = position - 1'b1;
    assign pos_cmp  = CMP_W'(position);
    assign cnt_cmp  = CMP_W'(cnt_reg);
    assign is_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign is_empty = (cnt_reg == '0);

    // middle position test: 2 .. count
    always_comb
    begin
        if ((position == '0) || (pos_cmp > cnt_cmp))
            mid_st = ST_RANGE;
        else if (position == POS_W'(1))
            mid_st = ST_NOTMID;
        else
            mid_st = ST_OK;
    end

    // command decode: status, chain operation and next count
    always_comb
    begin
        op_c     = CELL_HOLD;
        idx_c    = '0;
        st_c     = ST_OK;
        cnt_next = cnt_reg;
        go_read  = 1'b0;
        if (state_reg == S_READ)
        begin
            // rotate the live words one place toward the front
            op_c  = CELL_ROT;
            idx_c = cnt_m1[IDX_W-1:0];
        end
        else if (accept)
        begin
            case (mode)
                MODE_INS_FRONT:
                begin
                    if (is_full)
                        st_c = ST_FULL;
                    else
                    begin
                        op_c     = CELL_INS;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                MODE_INS_BACK:
                begin
                    if (is_full)
                        st_c = ST_FULL;
                    else
                    begin
                        op_c     = CELL_INS;
                        idx_c    = cnt_reg[IDX_W-1:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                MODE_INS_AT:
                begin
                    if (mid_st != ST_OK)
                        st_c = mid_st;
                    else if (is_full)
                        st_c = ST_FULL;
                    else
                    begin
                        op_c     = CELL_INS;
                        idx_c    = pos_m1[IDX_W-1:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                MODE_DEL_FRONT:
                begin
                    if (is_empty)
                        st_c = ST_EMPTY;
                    else
                    begin
                        op_c     = CELL_DEL;
                        cnt_next = cnt_m1;
                    end
                end
                MODE_DEL_BACK:
                begin
                    // back word simply drops out of the live range
                    if (is_empty)
                        st_c = ST_EMPTY;
                    else
                        cnt_next = cnt_m1;
                end
                MODE_DEL_AT:
                begin
                    if (mid_st != ST_OK)
                        st_c = mid_st;
                    else
                    begin
                        op_c     = CELL_DEL;
                        idx_c    = pos_m1[IDX_W-1:0];
                        cnt_next = cnt_m1;
                    end
                end
                MODE_UPD_FRONT:
                begin
                    if (is_empty)
                        st_c = ST_EMPTY;
                    else
                        op_c = CELL_UPD;
                end
                MODE_UPD_BACK:
                begin
                    if (is_empty)
                        st_c = ST_EMPTY;
                    else
                    begin
                        op_c  = CELL_UPD;
                        idx_c = cnt_m1[IDX_W-1:0];
                    end
                end
                MODE_UPD_AT:
                begin
                    if (is_empty)
                        st_c = ST_EMPTY;
                    else if (mid_st != ST_OK)
                        st_c = mid_st;
                    else
                    begin
                        op_c  = CELL_UPD;
                        idx_c = pos_m1[IDX_W-1:0];
                    end
                end
                MODE_CLEAR:
                begin
                    cnt_next = '0;
                end
                MODE_READ_ALL:
                begin
                    if (is_empty)
                        st_c = ST_EMPTY;
                    else
                        go_read = 1'b1;
                end
                default:
                begin
                    st_c = ST_OK;   // unused codes: no change
                end
            endcase
        end
    end

    // the cell chain; end cells feed back their own word where no neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = vals[i];
        end
        else
        begin : g_mid_l
            assign left_w = vals[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_end
            assign right_w = vals[i];
        end
        else
        begin : g_mid_r
            assign right_w = vals[i+1];
        end

        pvl_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .op        (op_c),
            .idx       (idx_c),
            .value     (value),
            .left_val  (left_w),
            .right_val (right_w),
            .front_val (vals[0]),
            .q         (vals[i])
        );
    end

    // control state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rd_reg      <= '0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            element_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= 1'b0;
            if (state_reg == S_READ)
            begin
                status_reg  <= ST_OK;
                element_reg <= vals[0];
                last_reg    <= (rd_reg == cnt_m1);
            end
            else
            begin
                status_reg  <= st_c;
                element_reg <= '0;
                last_reg    <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (go_read)
                        begin
                            state_reg <= S_READ;
                            rd_reg    <= '0;
                        end
                        else
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    done_reg <= 1'b1;
                    rd_reg   <= rd_reg + 1'b1;
                    if (rd_reg == cnt_m1)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    logic [CNT_W+COUNT_W-1:0] cnt_ext;
    assign cnt_ext = {{COUNT_W{1'b0}}, cnt_reg};

    assign busy    = (state_reg == S_READ);
    assign done    = done_reg;
    assign status  = status_reg;
    assign element = element_reg;
    assign count   = cnt_ext[COUNT_W-1:0];
    assign last    = last_reg;

    // read-out bursts run without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> done)
    else $error("read-out burst broken");

    // count stays within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
    else $error("count above capacity");

    // a single-result command answers on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode != MODE_READ_ALL)) |=> (done && last))
    else $error("missing single result");

    // read-out only runs over a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (cnt_reg != '0))
    else $error("read-out on empty list");

endmodule
